// ===== hw/rtl/event_watch_filter_queue_assert.svh =====
// Assertion macros shared by the event watch filter queue RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef EVENT_WATCH_FILTER_QUEUE_ASSERT_SVH
`define EVENT_WATCH_FILTER_QUEUE_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define EWFQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle
`define EWFQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ewfq_pkg.sv =====
// Shared codes, widths and reset constants for the event watch filter queue.
// No dependencies.
`default_nettype none

package ewfq_pkg;

    // Field widths
    localparam int OBJ_W  = 32;
    localparam int MASK_W = 64;
    localparam int PID_W  = 31;
    localparam int FILE_W = 32;

    typedef logic [2:0] t_req_type;
    typedef logic [2:0] t_status;
    typedef logic [1:0] t_outcome;
    typedef logic [1:0] t_cfg_index;

    // Request kinds
    localparam t_req_type REQ_EVENT  = 3'd0;
    localparam t_req_type REQ_ADD    = 3'd1;
    localparam t_req_type REQ_REMOVE = 3'd2;
    localparam t_req_type REQ_FLUSH  = 3'd3;
    localparam t_req_type REQ_READ   = 3'd4;

    // Status codes
    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_INVALID    = 3'd1;
    localparam t_status ST_NOT_FOUND  = 3'd2;
    localparam t_status ST_TABLE_FULL = 3'd3;
    localparam t_status ST_EMPTY      = 3'd4;

    // Event outcomes
    localparam t_outcome OC_NO_MATCH = 2'd0;
    localparam t_outcome OC_QUEUED   = 2'd1;
    localparam t_outcome OC_OVERFLOW = 2'd2;
    localparam t_outcome OC_DROPPED  = 2'd3;

    // Configuration register indexes
    localparam t_cfg_index CFG_QUEUE_LIMIT   = 2'd0;
    localparam t_cfg_index CFG_HANDLE_MODE   = 2'd1;
    localparam t_cfg_index CFG_OVERFLOW_CODE = 2'd2;

    // Register reset values
    localparam logic [6:0]        QUEUE_LIMIT_RESET   = 7'd64;
    localparam logic [MASK_W-1:0] OVERFLOW_CODE_RESET = 64'd16384;

endpackage

`default_nettype wire

// ===== hw/rtl/ewfq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ewfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/event_watch_filter_queue.sv =====
// Event watch filter queue: watch table scan sequencer plus bounded record FIFO.
// Depends on ewfq_pkg, ewfq_ram and event_watch_filter_queue_assert.svh.
//
// Flush, unknown, zero-mask and empty-queue read requests go from dispatch straight to
// the result; reads that pop a record pass through a read state first. Events, mark adds
// and removes scan k entries (k at most MARK_ENTRIES), each in a read and a compare state
// through the single mark memory read port and the shared comparator, then an action state.
// One request is in flight at a time; the next can be taken while a result waits in the
// output register. Reset (i_rst_n low, synchronous) clears control, pointers, marks and
// config.
`default_nettype none

module event_watch_filter_queue #(
    parameter int MARK_ENTRIES = 16,
    parameter int QUEUE_DEPTH  = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Configuration write port
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data,
    // Request stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] object_id, [95:32] event_mask, [126:96] origin_pid,
    // [158:127] file_ref, [159] zero
    input  wire logic [159:0] s_tdata,
    // [2:0] req_type, [3] ignore_select
    input  wire logic [3:0]   s_tuser,
    // Result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [63:0] record_mask, [94:64] record_pid, [126:95] record_file_ref, [127] zero
    output logic      [127:0] m_tdata,
    // [2:0] status, [4:3] event_outcome, [5] record_valid
    output logic      [5:0]   m_tuser
);

    localparam int OBJ_W  = ewfq_pkg::OBJ_W;
    localparam int MASK_W = ewfq_pkg::MASK_W;
    localparam int PID_W  = ewfq_pkg::PID_W;
    localparam int FILE_W = ewfq_pkg::FILE_W;

    localparam int MIW    = (MARK_ENTRIES > 1) ? $clog2(MARK_ENTRIES) : 1;
    localparam int SLOTS  = QUEUE_DEPTH + 1;
    localparam int QAW    = $clog2(SLOTS);
    localparam int QCW    = $clog2(SLOTS + 1);
    localparam int LW     = (QCW > 7) ? QCW : 7;
    localparam int MRW    = OBJ_W + 2 * MASK_W;
    localparam int QRW    = MASK_W + PID_W + FILE_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISP     = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CMP = 3'd3;
    localparam logic [2:0] S_ACT      = 3'd4;
    localparam logic [2:0] S_READ     = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] r_state;

    // Configuration registers
    logic [6:0]        r_queue_limit;
    logic              r_handle_mode;
    logic [MASK_W-1:0] r_overflow_code;

    // Latched request
    ewfq_pkg::t_req_type r_req;
    logic [OBJ_W-1:0]    r_obj;
    logic [MASK_W-1:0]   r_mask;
    logic                r_ign;
    logic [PID_W-1:0]    r_pid;
    logic [FILE_W-1:0]   r_file;

    // Scan bookkeeping
    logic [MIW-1:0]    r_idx;
    logic              r_found;
    logic [MIW-1:0]    r_hit_idx;
    logic [MASK_W-1:0] r_hit_watch;
    logic [MASK_W-1:0] r_hit_ign;
    logic              r_free_found;
    logic [MIW-1:0]    r_free_idx;
    logic [MARK_ENTRIES-1:0] r_mvalid;

    // Queue pointers
    logic [QAW-1:0] r_head;
    logic [QAW-1:0] r_tail;
    logic [QCW-1:0] r_count;
    logic           r_ovf;
    logic [QAW-1:0] n_head;
    logic [QAW-1:0] n_tail;

    // Staged result
    ewfq_pkg::t_status  r_res_status;
    ewfq_pkg::t_outcome r_res_outcome;
    logic               r_res_rvalid;
    logic [MASK_W-1:0]  r_res_mask;
    logic [PID_W-1:0]   r_res_pid;
    logic [FILE_W-1:0]  r_res_file;

    // Output register
    logic               r_m_valid;
    ewfq_pkg::t_status  r_o_status;
    ewfq_pkg::t_outcome r_o_outcome;
    logic               r_o_rvalid;
    logic [MASK_W-1:0]  r_o_mask;
    logic [PID_W-1:0]   r_o_pid;
    logic [FILE_W-1:0]  r_o_file;

    // Memory ports
    logic           w_mark_we;
    logic [MIW-1:0] w_mark_waddr;
    logic [MRW-1:0] w_mark_wdata;
    logic [MRW-1:0] w_mark_rdata;
    logic           w_q_we;
    logic [QRW-1:0] w_q_wdata;
    logic [QRW-1:0] w_q_rdata;

    // Mark scan and action logic
    logic [OBJ_W-1:0]  w_rd_obj;
    logic [MASK_W-1:0] w_rd_watch;
    logic [MASK_W-1:0] w_rd_ign;
    logic              w_hit;
    logic [MIW-1:0]    w_tgt_idx;
    logic [MASK_W-1:0] w_base_watch;
    logic [MASK_W-1:0] w_base_ign;
    logic [MASK_W-1:0] w_new_watch;
    logic [MASK_W-1:0] w_new_ign;
    logic              w_evt_match;
    logic [LW-1:0]     w_lim;
    logic              w_below;
    logic              w_slot_free;
    logic              w_accept;
    logic              w_out_free;

    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_m_valid || m_tready;
    assign s_tready   = (r_state == S_IDLE);

    // Mark entry as read from memory
    assign w_rd_obj   = w_mark_rdata[MRW-1 -: OBJ_W];
    assign w_rd_watch = w_mark_rdata[2*MASK_W-1 -: MASK_W];
    assign w_rd_ign   = w_mark_rdata[MASK_W-1:0];
    assign w_hit      = r_mvalid[r_idx] && (w_rd_obj == r_obj);

    // Entry an add or remove works on, and its new masks
    assign w_tgt_idx    = r_found ? r_hit_idx : r_free_idx;
    assign w_base_watch = r_found ? r_hit_watch : '0;
    assign w_base_ign   = r_found ? r_hit_ign : '0;

    always_comb begin
        w_new_watch = w_base_watch;
        w_new_ign   = w_base_ign;
        if (r_req == ewfq_pkg::REQ_ADD) begin
            if (r_ign) begin
                w_new_ign = w_base_ign | r_mask;
            end else begin
                w_new_watch = w_base_watch | r_mask;
            end
        end else begin
            if (r_ign) begin
                w_new_ign = w_base_ign & ~r_mask;
            end else begin
                w_new_watch = w_base_watch & ~r_mask;
            end
        end
    end

    // Queue bound: zero or beyond the physical depth means the physical depth
    always_comb begin
        w_lim = LW'(r_queue_limit);
        if (r_queue_limit == 7'd0 || LW'(r_queue_limit) > LW'(QUEUE_DEPTH)) begin
            w_lim = LW'(QUEUE_DEPTH);
        end
    end

    assign w_evt_match = r_found && ((r_hit_watch & r_mask) != '0)
                         && ((r_hit_ign & r_mask) == '0);
    assign w_below     = LW'(r_count) < w_lim;
    assign w_slot_free = r_count != QCW'(SLOTS);

    assign n_head = (r_head == QAW'(QUEUE_DEPTH)) ? '0 : r_head + 1'b1;
    assign n_tail = (r_tail == QAW'(QUEUE_DEPTH)) ? '0 : r_tail + 1'b1;

    // Memory write strobes, only in the action state
    always_comb begin
        w_mark_we    = 1'b0;
        w_mark_waddr = w_tgt_idx;
        w_mark_wdata = {r_obj, w_new_watch, w_new_ign};
        w_q_we       = 1'b0;
        w_q_wdata    = {r_mask, r_pid, (r_handle_mode ? FILE_W'(0) : r_file)};
        if (r_state == S_ACT) begin
            case (r_req)
                ewfq_pkg::REQ_EVENT: begin
                    if (w_evt_match) begin
                        if (w_below) begin
                            w_q_we = 1'b1;
                        end else if (!r_ovf && w_slot_free) begin
                            w_q_we    = 1'b1;
                            w_q_wdata = {r_overflow_code, r_pid, FILE_W'(0)};
                        end
                    end
                end
                ewfq_pkg::REQ_ADD: begin
                    w_mark_we = r_found || r_free_found;
                end
                ewfq_pkg::REQ_REMOVE: begin
                    w_mark_we = r_found;
                end
                default: begin
                    w_mark_we = 1'b0;
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit   <= ewfq_pkg::QUEUE_LIMIT_RESET;
            r_handle_mode   <= 1'b0;
            r_overflow_code <= ewfq_pkg::OVERFLOW_CODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ewfq_pkg::CFG_QUEUE_LIMIT:   r_queue_limit   <= i_cfg_data[6:0];
                ewfq_pkg::CFG_HANDLE_MODE:   r_handle_mode   <= i_cfg_data[0];
                ewfq_pkg::CFG_OVERFLOW_CODE: r_overflow_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= s_tuser[2:0];
            r_ign  <= s_tuser[3];
            r_obj  <= s_tdata[31:0];
            r_mask <= s_tdata[95:32];
            r_pid  <= s_tdata[126:96];
            r_file <= s_tdata[158:127];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mvalid     <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state       <= S_DISP;
                        r_res_status  <= ewfq_pkg::ST_OK;
                        r_res_outcome <= ewfq_pkg::OC_NO_MATCH;
                        r_res_rvalid  <= 1'b0;
                        r_res_mask    <= '0;
                        r_res_pid     <= '0;
                        r_res_file    <= '0;
                    end
                end
                S_DISP: begin
                    r_idx        <= '0;
                    r_found      <= 1'b0;
                    r_free_found <= 1'b0;
                    case (r_req)
                        ewfq_pkg::REQ_EVENT: begin
                            if (r_mask != '0) begin
                                r_state <= S_SCAN_RD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        ewfq_pkg::REQ_ADD, ewfq_pkg::REQ_REMOVE: begin
                            if (r_mask == '0) begin
                                r_res_status <= ewfq_pkg::ST_INVALID;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_SCAN_RD;
                            end
                        end
                        ewfq_pkg::REQ_FLUSH: begin
                            r_mvalid <= '0;
                            r_state  <= S_DONE;
                        end
                        ewfq_pkg::REQ_READ: begin
                            if (r_count == '0) begin
                                r_res_status <= ewfq_pkg::ST_EMPTY;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_READ;
                            end
                        end
                        default: begin
                            r_res_status <= ewfq_pkg::ST_INVALID;
                            r_state      <= S_DONE;
                        end
                    endcase
                end
                // Memory read of entry r_idx in flight
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CMP;
                end
                // Shared tag compare, one entry per pass
                S_SCAN_CMP: begin
                    if (!r_mvalid[r_idx] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_idx;
                    end
                    if (w_hit) begin
                        r_found     <= 1'b1;
                        r_hit_idx   <= r_idx;
                        r_hit_watch <= w_rd_watch;
                        r_hit_ign   <= w_rd_ign;
                        r_state     <= S_ACT;
                    end else if (r_idx == MIW'(MARK_ENTRIES - 1)) begin
                        r_state <= S_ACT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_ACT: begin
                    r_state <= S_DONE;
                    case (r_req)
                        ewfq_pkg::REQ_EVENT: begin
                            if (w_evt_match) begin
                                if (w_below) begin
                                    r_tail        <= n_tail;
                                    r_count       <= r_count + 1'b1;
                                    r_ovf         <= 1'b0;
                                    r_res_outcome <= ewfq_pkg::OC_QUEUED;
                                end else if (!r_ovf && w_slot_free) begin
                                    r_tail        <= n_tail;
                                    r_count       <= r_count + 1'b1;
                                    r_ovf         <= 1'b1;
                                    r_res_outcome <= ewfq_pkg::OC_OVERFLOW;
                                end else begin
                                    r_res_outcome <= ewfq_pkg::OC_DROPPED;
                                end
                            end
                        end
                        ewfq_pkg::REQ_ADD: begin
                            if (r_found || r_free_found) begin
                                r_mvalid[w_tgt_idx] <= 1'b1;
                            end else begin
                                r_res_status <= ewfq_pkg::ST_TABLE_FULL;
                            end
                        end
                        ewfq_pkg::REQ_REMOVE: begin
                            if (!r_found) begin
                                r_res_status <= ewfq_pkg::ST_NOT_FOUND;
                            end else if (w_new_watch == '0) begin
                                r_mvalid[w_tgt_idx] <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                // Head record arrives from the queue memory
                S_READ: begin
                    r_res_rvalid <= 1'b1;
                    r_res_mask   <= w_q_rdata[QRW-1 -: MASK_W];
                    r_res_pid    <= w_q_rdata[FILE_W +: PID_W];
                    r_res_file   <= w_q_rdata[FILE_W-1:0];
                    r_head       <= n_head;
                    r_count      <= r_count - 1'b1;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register, loaded once the previous result has been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_o_status  <= r_res_status;
            r_o_outcome <= r_res_outcome;
            r_o_rvalid  <= r_res_rvalid;
            r_o_mask    <= r_res_mask;
            r_o_pid     <= r_res_pid;
            r_o_file    <= r_res_file;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {1'b0, r_o_file, r_o_pid, r_o_mask};
    assign m_tuser  = {r_o_rvalid, r_o_outcome, r_o_status};

    // Watch table: object, watch mask, ignore mask per entry
    ewfq_ram #(
        .WIDTH (MRW),
        .DEPTH (MARK_ENTRIES),
        .AW    (MIW)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (w_mark_we),
        .i_waddr (w_mark_waddr),
        .i_wdata (w_mark_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_mark_rdata)
    );

    // Record queue: mask, pid, file handle per slot, spare slot for overflow
    ewfq_ram #(
        .WIDTH (QRW),
        .DEPTH (SLOTS),
        .AW    (QAW)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (r_tail),
        .i_wdata (w_q_wdata),
        .i_raddr (r_head),
        .o_rdata (w_q_rdata)
    );

    // Checks
`include "event_watch_filter_queue_assert.svh"

    `EWFQ_ASSERT_ALWAYS(a_count_bound, r_count <= QCW'(SLOTS), "queue count beyond slots")
    `EWFQ_ASSERT_IMPLY(a_read_nonempty, r_state == S_READ, r_count != '0, "pop from empty queue")
    `EWFQ_ASSERT_IMPLY(a_record_ok, m_tvalid && r_o_rvalid,
        r_o_status == ewfq_pkg::ST_OK && r_o_outcome == ewfq_pkg::OC_NO_MATCH,
        "record result with bad status")
    `EWFQ_ASSERT_IMPLY(a_outcome_event, m_tvalid && r_o_outcome != ewfq_pkg::OC_NO_MATCH,
        r_o_status == ewfq_pkg::ST_OK && !r_o_rvalid, "event outcome on non-event result")

endmodule

`default_nettype wire

// ===== dv/event_watch_filter_queue_test.sv =====
// Self-checking testbench for event_watch_filter_queue: watch table, event filter and
// bounded record FIFO with overflow record. Needs ewfq_pkg and the block's RTL only.
`timescale 1ns / 100ps

module event_watch_filter_queue_test;

    import ewfq_pkg::*;

    localparam int MARK_N        = 16;
    localparam int FIFO_DEPTH    = 64;
    localparam int CLK_PERIOD    = 10;
    localparam int POOL_N        = 20;   // more objects than table entries
    localparam int LANES         = 6;    // mask bits shared by marks and events in a phase
    localparam int SETUP_ADDS    = 12;
    localparam int PHASE_COUNT   = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 8;
    localparam int TAIL_CYCLES   = 60;
    localparam int IDLE_LIMIT    = 4000;
    localparam int REPORT_CAP    = 40;

    // Request kinds the block must reject
    localparam t_req_type REQ_RESERVED_FIRST = 3'd5;
    localparam t_req_type REQ_RESERVED_LAST  = 3'd7;

    typedef enum logic [1:0] {PLAN_REQUEST, PLAN_CONFIG, PLAN_DRAIN} plan_kind_e;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_STRIDE} rx_style_e;

    typedef struct {
        plan_kind_e          kind;
        t_req_type           req;
        logic [OBJ_W-1:0]    obj;
        logic [MASK_W-1:0]   mask;
        logic                ign;
        logic [PID_W-1:0]    pid;
        logic [FILE_W-1:0]   file;
        t_cfg_index          index;
        logic [63:0]         value;
    } plan_item_t;

    typedef struct {
        t_status             status;
        t_outcome            outcome;
        logic                rvalid;
        logic [MASK_W-1:0]   rmask;
        logic [PID_W-1:0]    rpid;
        logic [FILE_W-1:0]   rfile;
    } reply_t;

    typedef struct {
        logic [MASK_W-1:0]   mask;
        logic [PID_W-1:0]    pid;
        logic [FILE_W-1:0]   file;
    } fifo_record_t;

    // Clock, reset and block ports
    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_cfg_we    = 1'b0;
    logic [1:0]     i_cfg_index = '0;
    logic [63:0]    i_cfg_data  = '0;
    logic           s_tvalid    = 1'b0;
    logic           s_tready;
    // [31:0] object_id, [95:32] event_mask, [126:96] origin_pid, [158:127] file_ref
    logic [159:0]   s_tdata     = '0;
    // [2:0] req_type, [3] ignore_select
    logic [3:0]     s_tuser     = '0;
    logic           m_tvalid;
    logic           m_tready    = 1'b0;
    // [63:0] record_mask, [94:64] record_pid, [126:95] record_file_ref
    logic [127:0]   m_tdata;
    // [2:0] status, [4:3] event_outcome, [5] record_valid
    logic [5:0]     m_tuser;

    // Model of the listener context
    logic               wt_valid  [MARK_N];
    logic [OBJ_W-1:0]   wt_object [MARK_N];
    logic [MASK_W-1:0]  wt_watch  [MARK_N];
    logic [MASK_W-1:0]  wt_ignore [MARK_N];
    fifo_record_t       event_fifo[$];
    logic               ovf_pending;
    logic [6:0]         cfg_limit;
    logic               cfg_handle_mode;
    logic [MASK_W-1:0]  cfg_ovf_code;

    plan_item_t     request_plan[$];
    reply_t         replies_due[$];
    int unsigned    lane_bit[LANES];

    // Handshake bookkeeping shared between driver and monitor
    logic           req_accepted = 1'b0;
    int             quiet_cycles = 0;
    int             burst_left   = 8;
    int             gap_left     = 0;
    int             idle_watch   = 0;
    rx_style_e      rx_style     = RX_OPEN;
    int             rx_span      = 0;
    int unsigned    rx_tick      = 0;

    int             mismatches     = 0;
    int             requests_seen  = 0;
    int             replies_seen   = 0;
    int             config_writes  = 0;
    int             tally_queued   = 0;
    int             tally_overflow = 0;
    int             tally_dropped  = 0;
    int             tally_full     = 0;
    int             tally_empty    = 0;

    event_watch_filter_queue #(
        .MARK_ENTRIES (MARK_N),
        .QUEUE_DEPTH  (FIFO_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------

    function automatic int find_mark(input logic [OBJ_W-1:0] obj);
        int i;
        for (i = 0; i < MARK_N; i++)
            if (wt_valid[i] && wt_object[i] == obj)
                return i;
        return -1;
    endfunction

    // Applies one request to the model and returns the reply it must produce
    function automatic reply_t compute_reply(input plan_item_t it);
        reply_t       r;
        fifo_record_t rec;
        int           hit;
        int           bound;
        int           i;
        r = '{status: ST_OK, outcome: OC_NO_MATCH, rvalid: 1'b0,
              rmask: '0, rpid: '0, rfile: '0};
        hit = -1;
        case (it.req)
            REQ_EVENT: begin
                if (it.mask != '0)
                    hit = find_mark(it.obj);
                if (hit >= 0 && (wt_watch[hit] & it.mask) != '0
                        && (wt_ignore[hit] & it.mask) == '0) begin
                    bound = (cfg_limit == 0 || cfg_limit > FIFO_DEPTH) ? FIFO_DEPTH
                                                                     : int'(cfg_limit);
                    if (event_fifo.size() < bound) begin
                        rec = '{mask: it.mask, pid: it.pid,
                                file: cfg_handle_mode ? 32'd0 : it.file};
                        event_fifo.push_back(rec);
                        ovf_pending = 1'b0;
                        r.outcome = OC_QUEUED;
                        tally_queued++;
                    end else if (!ovf_pending && event_fifo.size() < FIFO_DEPTH + 1) begin
                        // one overflow record fits in the spare slot
                        rec = '{mask: cfg_ovf_code, pid: it.pid, file: 32'd0};
                        event_fifo.push_back(rec);
                        ovf_pending = 1'b1;
                        r.outcome = OC_OVERFLOW;
                        tally_overflow++;
                    end else begin
                        r.outcome = OC_DROPPED;
                        tally_dropped++;
                    end
                end
            end
            REQ_ADD, REQ_REMOVE: begin
                if (it.mask == '0) begin
                    r.status = ST_INVALID;
                end else begin
                    hit = find_mark(it.obj);
                    if (it.req == REQ_ADD) begin
                        if (hit < 0) begin
                            // lowest free entry
                            for (i = MARK_N - 1; i >= 0; i--)
                                if (!wt_valid[i])
                                    hit = i;
                            if (hit < 0) begin
                                r.status = ST_TABLE_FULL;
                                tally_full++;
                            end else begin
                                wt_valid[hit]  = 1'b1;
                                wt_object[hit] = it.obj;
                                wt_watch[hit]  = '0;
                                wt_ignore[hit] = '0;
                            end
                        end
                        if (hit >= 0) begin
                            if (it.ign)
                                wt_ignore[hit] |= it.mask;
                            else
                                wt_watch[hit] |= it.mask;
                        end
                    end else if (hit < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        if (it.ign)
                            wt_ignore[hit] &= ~it.mask;
                        else
                            wt_watch[hit] &= ~it.mask;
                        if (wt_watch[hit] == '0)
                            wt_valid[hit] = 1'b0;
                    end
                end
            end
            REQ_FLUSH: begin
                for (i = 0; i < MARK_N; i++)
                    wt_valid[i] = 1'b0;
            end
            REQ_READ: begin
                if (event_fifo.size() == 0) begin
                    r.status = ST_EMPTY;
                    tally_empty++;
                end else begin
                    rec = event_fifo.pop_front();
                    r.rvalid = 1'b1;
                    r.rmask  = rec.mask;
                    r.rpid   = rec.pid;
                    r.rfile  = rec.file;
                end
            end
            default: r.status = ST_INVALID;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------

    function automatic void push_request(input t_req_type req, input logic [OBJ_W-1:0] obj,
                                         input logic [MASK_W-1:0] mask, input logic ign,
                                         input logic [PID_W-1:0] pid,
                                         input logic [FILE_W-1:0] file);
        plan_item_t it;
        it.kind = PLAN_REQUEST;
        it.req  = req;
        it.obj  = obj;
        it.mask = mask;
        it.ign  = ign;
        it.pid  = pid;
        it.file = file;
        request_plan.push_back(it);
    endfunction

    function automatic void push_config(input t_cfg_index index, input logic [63:0] value);
        plan_item_t it;
        it.kind  = PLAN_CONFIG;
        it.index = index;
        it.value = value;
        request_plan.push_back(it);
    endfunction

    // OR of a few of this phase's shared bits
    function automatic logic [MASK_W-1:0] lane_mask(input int unsigned n);
        logic [MASK_W-1:0] m;
        int unsigned       k;
        m = '0;
        for (k = 0; k < n; k++)
            m[lane_bit[$urandom_range(0, LANES - 1)]] = 1'b1;
        return m;
    endfunction

    // Mostly shared bits, sometimes zero, all ones or fully random
    function automatic logic [MASK_W-1:0] pick_mask(input int unsigned lanes_max);
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3:    return {$urandom, $urandom};
            default: return lane_mask($urandom_range(1, lanes_max));
        endcase
    endfunction

    task automatic plan_phase(input int unsigned len, input int unsigned read_pct);
        logic [OBJ_W-1:0] pool[POOL_N];
        logic [OBJ_W-1:0] obj;
        plan_item_t       drain;
        int unsigned      n;
        int unsigned      roll;
        drain.kind = PLAN_DRAIN;
        for (n = 0; n < POOL_N; n++)
            pool[n] = $urandom;
        for (n = 0; n < LANES; n++)
            lane_bit[n] = $urandom_range(0, 63);
        // open with watches on most of the pool so events have something to hit
        for (n = 0; n < SETUP_ADDS; n++)
            push_request(REQ_ADD, pool[n], lane_mask(3), 1'b0, PID_W'($urandom), '0);
        for (n = SETUP_ADDS; n < len; n++) begin
            if (n == len / 2)
                request_plan.push_back(drain);
            obj  = ($urandom_range(0, 9) == 0) ? $urandom
                                               : pool[$urandom_range(0, POOL_N - 1)];
            roll = $urandom_range(0, 99);
            if (roll < read_pct) begin
                push_request(REQ_READ, obj, {$urandom, $urandom}, 1'($urandom),
                             PID_W'($urandom), $urandom);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 58)
                    push_request(REQ_EVENT, obj, pick_mask(2), 1'($urandom),
                                 PID_W'($urandom),
                                 ($urandom_range(0, 6) == 0) ? 32'd0 : $urandom);
                else if (roll < 76)
                    push_request(REQ_ADD, obj, pick_mask(3), $urandom_range(0, 3) == 0,
                                 PID_W'($urandom), $urandom);
                else if (roll < 94)
                    push_request(REQ_REMOVE, obj, pick_mask(2), $urandom_range(0, 2) == 0,
                                 PID_W'($urandom), $urandom);
                else if (roll < 96)
                    push_request(REQ_FLUSH, obj, {$urandom, $urandom}, 1'($urandom),
                                 PID_W'($urandom), $urandom);
                else
                    push_request(t_req_type'($urandom_range(REQ_RESERVED_FIRST,
                                                            REQ_RESERVED_LAST)),
                                 obj, {$urandom, $urandom}, 1'($urandom),
                                 PID_W'($urandom), $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: falling edge, bursts with random gaps
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        plan_item_t head;
        logic       send;
        logic       write_cfg;
        if (i_rst_n && !(s_tvalid && !req_accepted)) begin
            send         = 1'b0;
            write_cfg    = 1'b0;
            quiet_cycles = (replies_due.size() == 0) ? quiet_cycles + 1 : 0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (request_plan.size() != 0) begin
                head = request_plan[0];
                case (head.kind)
                    PLAN_REQUEST: begin
                        send = 1'b1;
                        s_tdata <= {1'b0, head.file, head.pid, head.mask, head.obj};
                        s_tuser <= {head.ign, head.req};
                        void'(request_plan.pop_front());
                        if (burst_left > 1) begin
                            burst_left--;
                        end else begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                     : $urandom_range(1, 12);
                        end
                    end
                    PLAN_CONFIG: begin
                        // registers change only with nothing in flight
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            write_cfg = 1'b1;
                            i_cfg_index <= head.index;
                            i_cfg_data  <= head.value;
                            void'(request_plan.pop_front());
                        end
                    end
                    default: begin
                        if (quiet_cycles >= HOLD_CYCLES)
                            void'(request_plan.pop_front());
                    end
                endcase
            end
            s_tvalid <= send;
            i_cfg_we <= write_cfg;
        end
    end

    // ------------------------------------------------------------------
    // Result stall pattern: the ready style is redrawn at random and held for a random span
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic ready_next;
        if (rx_span == 0) begin
            rx_style = rx_style_e'($urandom_range(0, 3));
            rx_span  = $urandom_range(40, 400);
        end else begin
            rx_span--;
        end
        rx_tick++;
        case (rx_style)
            RX_OPEN:   ready_next = 1'b1;
            RX_COIN:   ready_next = 1'($urandom);
            RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
            default:   ready_next = (rx_tick % 5) < 2;
        endcase
        m_tready <= ready_next;
    end

    // ------------------------------------------------------------------
    // Monitor: config tracking, result check, prediction and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        plan_item_t seen;
        reply_t     got;
        reply_t     want;
        int         i;
        if (!i_rst_n) begin
            for (i = 0; i < MARK_N; i++)
                wt_valid[i] = 1'b0;
            event_fifo.delete();
            ovf_pending     = 1'b0;
            cfg_limit       = QUEUE_LIMIT_RESET;
            cfg_handle_mode = 1'b0;
            cfg_ovf_code    = OVERFLOW_CODE_RESET;
            req_accepted    = 1'b0;
            idle_watch      = 0;
        end else begin
            req_accepted = s_tvalid && s_tready;

            if (i_cfg_we) begin
                config_writes++;
                case (i_cfg_index)
                    CFG_QUEUE_LIMIT:   cfg_limit       = i_cfg_data[6:0];
                    CFG_HANDLE_MODE:   cfg_handle_mode = i_cfg_data[0];
                    CFG_OVERFLOW_CODE: cfg_ovf_code    = i_cfg_data;
                    default: ;
                endcase
            end

            // results come back in request order
            if (m_tvalid && m_tready) begin
                replies_seen++;
                got.status  = m_tuser[2:0];
                got.outcome = m_tuser[4:3];
                got.rvalid  = m_tuser[5];
                got.rmask   = m_tdata[63:0];
                got.rpid    = m_tdata[94:64];
                got.rfile   = m_tdata[126:95];
                if (replies_due.size() == 0) begin
                    report_mismatch("result with nothing outstanding", m_tuser, '0);
                end else begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.outcome !== want.outcome)
                        report_mismatch("event_outcome", got.outcome, want.outcome);
                    if (got.rvalid !== want.rvalid)
                        report_mismatch("record_valid", got.rvalid, want.rvalid);
                    if (got.rmask !== want.rmask)
                        report_mismatch("record_mask", got.rmask, want.rmask);
                    if (got.rpid !== want.rpid)
                        report_mismatch("record_pid", got.rpid, want.rpid);
                    if (got.rfile !== want.rfile)
                        report_mismatch("record_file_ref", got.rfile, want.rfile);
                end
            end

            if (req_accepted) begin
                requests_seen++;
                seen.kind = PLAN_REQUEST;
                seen.req  = s_tuser[2:0];
                seen.ign  = s_tuser[3];
                seen.obj  = s_tdata[31:0];
                seen.mask = s_tdata[95:32];
                seen.pid  = s_tdata[126:96];
                seen.file = s_tdata[158:127];
                replies_due.push_back(compute_reply(seen));
            end

            if (req_accepted || (m_tvalid && m_tready) || i_cfg_we) begin
                idle_watch = 0;
            end else begin
                idle_watch = idle_watch + 1;
                if (idle_watch >= IDLE_LIMIT) begin
                    $display("[%0t] no transaction for %0d cycles, %0d results outstanding",
                             $realtime, IDLE_LIMIT, replies_due.size());
                    $display("** event_watch_filter_queue: FAILED **");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Plan, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [OBJ_W-1:0]  obj_a;
        logic [OBJ_W-1:0]  obj_b;
        logic [6:0]        lim;
        logic              mode;
        logic [MASK_W-1:0] code;
        int unsigned       reads;
        int unsigned       len;
        int                p;

        obj_a = $urandom;
        obj_b = '0;

        // Directed: empty queue, missing marks, filters and table edge cases
        push_request(REQ_READ,   obj_a, '0,      1'b0, '0, '0);
        push_request(REQ_EVENT,  obj_a, 64'h1,   1'b0, '0, '0);
        push_request(REQ_ADD,    obj_a, '0,      1'b0, '0, '0);
        push_request(REQ_REMOVE, obj_a, 64'hFF,  1'b0, '0, '0);
        push_request(REQ_ADD,    obj_a, 64'h0F,  1'b0, '0, '0);
        push_request(REQ_ADD,    obj_a, 64'h02,  1'b1, '0, '0);
        push_request(REQ_EVENT,  obj_a, 64'h1,   1'b0, '1, '1);
        push_request(REQ_EVENT,  obj_a, 64'h02,  1'b0, 31'd7, 32'd9);
        push_request(REQ_EVENT,  obj_a, 64'h30,  1'b0, 31'd7, 32'd9);
        push_request(REQ_EVENT,  obj_a, '0,      1'b0, 31'd7, 32'd9);
        push_request(REQ_ADD,    '1,    '1,      1'b0, '0, '0);
        push_request(REQ_EVENT,  '1,    '1,      1'b1, '0, '0);
        // ignore-only mark: entry with an empty watch mask
        push_request(REQ_ADD,    obj_b, 64'h8000_0000_0000_0000, 1'b1, '0, '0);
        push_request(REQ_EVENT,  obj_b, 64'h8000_0000_0000_0000, 1'b0, '1, '1);
        push_request(REQ_REMOVE, obj_b, 64'h8000_0000_0000_0000, 1'b1, '0, '0);
        push_request(REQ_REMOVE, obj_b, 64'h1,   1'b0, '0, '0);
        push_request(REQ_REMOVE, obj_a, 64'h02,  1'b1, '0, '0);
        push_request(REQ_REMOVE, obj_a, 64'h0F,  1'b0, '0, '0);
        push_request(REQ_READ,   obj_a, '1,      1'b1, '1, '1);
        push_request(REQ_READ,   obj_a, '0,      1'b0, '0, '0);
        push_request(REQ_READ,   obj_a, '0,      1'b0, '0, '0);
        push_request(REQ_RESERVED_FIRST, obj_a, '1, 1'b1, '1, '1);
        push_request(REQ_RESERVED_LAST,  obj_a, '1, 1'b0, '0, '0);
        push_request(REQ_FLUSH,  '1,    '1,      1'b0, '0, '0);
        push_request(REQ_EVENT,  '1,    '1,      1'b0, '1, '1);

        // Random phases, each under its own register setting
        for (p = 0; p < PHASE_COUNT; p++) begin
            code = {$urandom, $urandom};
            case (p)
                0: begin lim = 7'd64;  mode = 1'b0; reads = 0;  len = 300; end
                1: begin lim = 7'd2;   mode = 1'b1; reads = 20; len = 150; code = '1; end
                2: begin lim = 7'd0;   mode = 1'b0; reads = 45; len = 150; code = '0; end
                3: begin lim = 7'd127; mode = 1'b1; reads = 8;  len = 150; end
                4: begin
                    lim = 7'd1; mode = 1'b0; reads = 25; len = 120;
                    code = OVERFLOW_CODE_RESET;
                end
                5: begin lim = 7'd65;  mode = 1'b0; reads = 4;  len = 180; end
                6: begin
                    lim = 7'($urandom_range(3, 63)); mode = 1'b1; reads = 30; len = 150;
                end
                7: begin lim = 7'd64;  mode = 1'b0; reads = 2;  len = 150; end
                8: begin
                    lim = 7'($urandom); mode = 1'($urandom); reads = 50; len = 130;
                end
                default: begin lim = 7'd5; mode = 1'b1; reads = 20; len = 100; end
            endcase
            push_config(CFG_QUEUE_LIMIT, {57'd0, lim});
            push_config(CFG_HANDLE_MODE, {63'd0, mode});
            push_config(CFG_OVERFLOW_CODE, code);
            plan_phase(len, reads);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_plan.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests in %0d register writes: %0d queued, %0d overflow records,",
                 requests_seen, config_writes, tally_queued, tally_overflow);
        $display("%0d dropped, %0d table-full adds, %0d empty reads; %0d results, %0d mismatches",
                 tally_dropped, tally_full, tally_empty, replies_seen, mismatches);
        if (mismatches == 0)
            $display("** event_watch_filter_queue: PASSED **");
        else
            $display("** event_watch_filter_queue: FAILED **");
        $finish;
    end

endmodule
